// ----- hw/rtl/sdd_pkg.sv -----
// Package for the signed date difference block: command struct, widths and calendar tables.
// No dependencies; used by sdd_ctrl, sdd_datapath and signed_date_difference.
package sdd_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int DN_W    = 23;
    localparam int DIFF_W  = 23;
    localparam int IN_W    = 48;
    localparam int OUT_W   = 24;

    // floor(y / 100) == (y * RECIP_100) >> RECIP_SHIFT for every 14-bit y.
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;
    localparam int          PROD_W      = YEAR_W + 13;
    localparam int          Q_W         = PROD_W - RECIP_SHIFT;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    typedef struct packed {
        logic load;
        logic mul;
        logic part;
        logic sum;
        logic sel;
        logic diff;
        logic fin;
    } sdd_cmd_t;

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] r;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
            4'd2:                                       r = leap ? 5'd29 : 5'd28;
            default:                                    r = 5'd0;
        endcase
        return r;
    endfunction

    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
        logic [8:0] r;
        case (m)
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- hw/rtl/sdd_ctrl.sv -----
// Controller for the signed date difference block: sequences the datapath one step a cycle.
// Depends on sdd_pkg for the command struct.
module sdd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output sdd_pkg::sdd_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_PART = 3'd2;
    localparam logic [2:0] ST_SUM  = 3'd3;
    localparam logic [2:0] ST_DIFF = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       sel_reg, sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sel_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                sel_next = 1'b0;
                if (in_valid)
                    state_next = ST_MUL;
            end
            ST_MUL:  state_next = ST_PART;
            ST_PART: state_next = ST_SUM;
            ST_SUM:
            begin
                if (sel_reg)
                    state_next = ST_DIFF;
                else
                begin
                    sel_next   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_DIFF: state_next = ST_FIN;
            ST_FIN:  state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    assign cmd.load = (state_reg == ST_IDLE) && in_valid;
    assign cmd.mul  = (state_reg == ST_MUL);
    assign cmd.part = (state_reg == ST_PART);
    assign cmd.sum  = (state_reg == ST_SUM);
    assign cmd.sel  = sel_reg;
    assign cmd.diff = (state_reg == ST_DIFF);
    assign cmd.fin  = (state_reg == ST_FIN);

endmodule

// ----- hw/rtl/sdd_datapath.sv -----
// Datapath for the signed date difference block: date checks, day numbers and the difference.
// Depends on sdd_pkg for widths, tables and the command struct.
module sdd_datapath #(
    parameter int MAX_YEAR = 9999
) (
    input  logic                       clk,
    input  sdd_pkg::sdd_cmd_t          cmd,
    input  logic [sdd_pkg::IN_W-1:0]   in_word,
    output logic [sdd_pkg::OUT_W-1:0]  out_word
);

    localparam logic [sdd_pkg::YEAR_W:0] YEAR_LIMIT = (sdd_pkg::YEAR_W + 1)'(MAX_YEAR);

    logic [sdd_pkg::IN_W-1:0]    in_reg;
    logic [sdd_pkg::Q_W-1:0]     q_reg;
    logic [sdd_pkg::DN_W-1:0]    p365_reg;
    logic [11:0]                 part_reg;
    logic [8:0]                  cum_reg;
    logic                        bad_reg;
    logic [sdd_pkg::DN_W-1:0]    n1_reg, n2_reg;
    logic                        lt_reg;
    logic [sdd_pkg::DN_W:0]      mag_reg;
    logic [sdd_pkg::OUT_W-1:0]   out_reg;

    logic [sdd_pkg::DAY_W-1:0]   d;
    logic [sdd_pkg::MONTH_W-1:0] m;
    logic [sdd_pkg::YEAR_W-1:0]  y, p;
    logic                        inc;
    logic [sdd_pkg::PROD_W-1:0]  prod;
    logic [sdd_pkg::YEAR_W:0]    q100;
    logic                        cent, leap, ok;
    logic [sdd_pkg::Q_W-1:0]     p100;
    logic [11:0]                 part;
    logic [8:0]                  cum;
    logic [sdd_pkg::DN_W-1:0]    n;
    logic [sdd_pkg::DN_W:0]      val, res;

    assign d   = cmd.sel ? in_reg[27:23] : in_reg[4:0];
    assign m   = cmd.sel ? in_reg[31:28] : in_reg[8:5];
    assign y   = cmd.sel ? in_reg[45:32] : in_reg[22:9];
    assign inc = in_reg[46];
    assign p   = y - 14'd1;

    assign prod = sdd_pkg::PROD_W'(y) * sdd_pkg::PROD_W'(sdd_pkg::RECIP_100);

    always_comb
    begin
        q100 = (sdd_pkg::YEAR_W + 1)'(q_reg) * 15'd100;
        cent = (q100 == {1'b0, y});
        leap = (y[1:0] == 2'd0) && (!cent || (q_reg[1:0] == 2'd0));
        p100 = q_reg - sdd_pkg::Q_W'(cent);
        part = 12'(p >> 2) - 12'(p100) + 12'(p100 >> 2);
        cum  = sdd_pkg::days_before(m) + 9'((m > sdd_pkg::MONTH_FEB) && leap);
        ok   = (y != '0) && ({1'b0, y} <= YEAR_LIMIT)
            && (m >= sdd_pkg::MONTH_JAN) && (m <= sdd_pkg::MONTH_DEC)
            && (d != '0) && (d <= sdd_pkg::month_days(m, leap));
        n    = p365_reg + sdd_pkg::DN_W'(part_reg) + sdd_pkg::DN_W'(cum_reg)
             + sdd_pkg::DN_W'(d);
        val  = mag_reg + (sdd_pkg::DN_W + 1)'(inc);
        res  = lt_reg ? val : -val;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            in_reg <= in_word;
        if (cmd.mul)
        begin
            q_reg    <= prod[sdd_pkg::PROD_W-1:sdd_pkg::RECIP_SHIFT];
            p365_reg <= sdd_pkg::DN_W'(p) * 23'd365;
        end
        if (cmd.part)
        begin
            part_reg <= part;
            cum_reg  <= cum;
            bad_reg  <= cmd.sel ? (bad_reg | !ok) : !ok;
        end
        if (cmd.sum)
        begin
            if (cmd.sel)
                n2_reg <= n;
            else
                n1_reg <= n;
        end
        if (cmd.diff)
        begin
            lt_reg  <= (n1_reg < n2_reg);
            mag_reg <= (n1_reg < n2_reg) ? {1'b0, n2_reg - n1_reg} : {1'b0, n1_reg - n2_reg};
        end
        if (cmd.fin)
            out_reg <= bad_reg ? {1'b1, {sdd_pkg::DIFF_W{1'b0}}}
                               : {1'b0, res[sdd_pkg::DIFF_W-1:0]};
    end

    assign out_word = out_reg;

endmodule

// ----- hw/rtl/signed_date_difference.sv -----
// Signed Gregorian date difference: one result word for each input word.
// From acceptance, each date passes a multiply, a partial-sum and a day-number step on the
// shared datapath, then subtract and sign. One word at a time: a new word can be taken
// in the cycle after the result is taken, at the earliest. Reset (rst_n low, asynchronous)
// returns the controller to idle.
// Depends on sdd_pkg, sdd_ctrl and sdd_datapath.
module signed_date_difference #(
    parameter int MAX_YEAR = 9999
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // first_day, first_month, first_year, second_day, second_month, second_year,
    // include_end, then one zero bit.
    input  logic [sdd_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // day_difference, bad_date.
    output logic [sdd_pkg::OUT_W-1:0] m_tdata
);

    sdd_pkg::sdd_cmd_t cmd;

    sdd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd)
    );

    sdd_datapath #(
        .MAX_YEAR (MAX_YEAR)
    ) u_datapath (
        .clk      (clk),
        .cmd      (cmd),
        .in_word  (s_tdata),
        .out_word (m_tdata)
    );

    assert property (@(posedge clk) disable iff (!rst_n) !(s_tready && m_tvalid))
        else $error("Input taken while a result is pending.");

    assert property (@(posedge clk) disable iff (!rst_n) s_tvalid && s_tready |=> !s_tready)
        else $error("Second word taken before the first was finished.");

    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.mul, cmd.part, cmd.sum, cmd.diff, cmd.fin}))
        else $error("More than one datapath step issued at once.");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[sdd_pkg::DIFF_W] |-> m_tdata[sdd_pkg::DIFF_W-1:0] == '0)
        else $error("Invalid date gave a non-zero difference.");

endmodule

// ----- bench/tb_signed_date_difference.sv -----
// Self-checking testbench for signed_date_difference: directed and random date pairs are
// streamed in, and each result word is checked against a calendar-based day count.
// Depends on sdd_pkg and the signed_date_difference RTL.
module tb_signed_date_difference;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_YEAR      = 9999;
    localparam int RANDOM_COUNT  = 1330;
    localparam int QUIET_TAIL    = 120;
    localparam int SETTLE_CYCLES = 20;
    localparam int DRAIN_LIMIT   = 5000;

    typedef struct packed {
        logic                        pad;
        logic                        include_end;
        logic [sdd_pkg::YEAR_W-1:0]  second_year;
        logic [sdd_pkg::MONTH_W-1:0] second_month;
        logic [sdd_pkg::DAY_W-1:0]   second_day;
        logic [sdd_pkg::YEAR_W-1:0]  first_year;
        logic [sdd_pkg::MONTH_W-1:0] first_month;
        logic [sdd_pkg::DAY_W-1:0]   first_day;
    } date_query_t;

    typedef struct packed {
        logic                              bad_date;
        logic signed [sdd_pkg::DIFF_W-1:0] day_difference;
    } day_result_t;

    typedef struct {
        int unsigned y;
        int unsigned m;
        int unsigned d;
    } cal_date_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    // first_day, first_month, first_year, second_day, second_month, second_year,
    // include_end, then one zero bit.
    logic [sdd_pkg::IN_W-1:0]   s_tdata = '0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    // day_difference, bad_date.
    logic [sdd_pkg::OUT_W-1:0]  m_tdata;

    date_query_t pending_queries[$];
    day_result_t expected_results[$];
    int          src_idle = 0;
    int          sink_idle = 0;
    int          mismatch_count = 0;
    int          words_checked = 0;
    int          invalid_seen = 0;
    int          query_count = 0;
    day_result_t got_word;
    day_result_t want_word;

    signed_date_difference #(
        .MAX_YEAR(MAX_YEAR)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit is_leap(int unsigned y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function automatic int unsigned month_length(int unsigned m, int unsigned y);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return is_leap(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    function automatic bit date_valid(int unsigned d, int unsigned m, int unsigned y);
        if (y < 1 || y > MAX_YEAR)
            return 1'b0;
        if (m < 1 || m > 12)
            return 1'b0;
        return d >= 1 && d <= month_length(m, y);
    endfunction

    // Days since the start of the calendar, the first day of year 1 counting as one.
    function automatic longint day_count(int unsigned d, int unsigned m, int unsigned y);
        longint p;
        longint n;
        p = y - 1;
        n = p * 365 + p / 4 - p / 100 + p / 400;
        for (int unsigned i = 1; i < m; i++)
            n += month_length(i, y);
        return n + d;
    endfunction

    function automatic day_result_t predict_difference(date_query_t q);
        day_result_t r;
        longint      n1;
        longint      n2;
        longint      inc;
        longint      span;
        r.bad_date       = 1'b0;
        r.day_difference = '0;
        if (!date_valid(q.first_day, q.first_month, q.first_year)
            || !date_valid(q.second_day, q.second_month, q.second_year))
        begin
            r.bad_date = 1'b1;
            return r;
        end
        inc = q.include_end;
        n1  = day_count(q.first_day, q.first_month, q.first_year);
        n2  = day_count(q.second_day, q.second_month, q.second_year);
        if (n1 < n2)
            span = n2 - n1 + inc;
        else
            span = -(n1 - n2 + inc);
        r.day_difference = span[sdd_pkg::DIFF_W-1:0];
        return r;
    endfunction

    function automatic cal_date_t make_date(int unsigned d, int unsigned m, int unsigned y);
        cal_date_t c;
        c.d = d;
        c.m = m;
        c.y = y;
        return c;
    endfunction

    // Years lean towards the ends of the range and towards century years.
    function automatic cal_date_t random_date();
        cal_date_t   c;
        int unsigned len;
        case ($urandom_range(9))
            0:       c.y = $urandom_range(3, 1);
            1:       c.y = $urandom_range(MAX_YEAR, MAX_YEAR - 3);
            2:       c.y = $urandom_range(99, 1) * 100;
            default: c.y = $urandom_range(MAX_YEAR, 1);
        endcase
        c.m = $urandom_range(12, 1);
        len = month_length(c.m, c.y);
        case ($urandom_range(9))
            0:       c.d = 1;
            1, 2:    c.d = len;
            default: c.d = $urandom_range(len, 1);
        endcase
        return c;
    endfunction

    function automatic cal_date_t corrupt_date(cal_date_t c);
        int unsigned len;
        len = month_length(c.m, c.y);
        case ($urandom_range(5))
            0:       c.d = 0;
            1:       c.d = (len < 31) ? $urandom_range(31, len + 1) : 0;
            2:       c.m = 0;
            3:       c.m = $urandom_range(15, 13);
            4:       c.y = 0;
            default: c.y = $urandom_range(16383, MAX_YEAR + 1);
        endcase
        return c;
    endfunction

    function automatic void add_query(cal_date_t a, cal_date_t b, bit inc);
        date_query_t q;
        q.pad          = 1'b0;
        q.include_end  = inc;
        q.first_day    = a.d[sdd_pkg::DAY_W-1:0];
        q.first_month  = a.m[sdd_pkg::MONTH_W-1:0];
        q.first_year   = a.y[sdd_pkg::YEAR_W-1:0];
        q.second_day   = b.d[sdd_pkg::DAY_W-1:0];
        q.second_month = b.m[sdd_pkg::MONTH_W-1:0];
        q.second_year  = b.y[sdd_pkg::YEAR_W-1:0];
        pending_queries.push_back(q);
    endfunction

    function automatic bit idling_on();
        return pending_queries.size() > QUIET_TAIL
            && ((pending_queries.size() / 150) % 3) != 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            src_idle <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_difference(date_query_t'(s_tdata)));
            if (!s_tvalid || s_tready)
            begin
                if (src_idle > 0)
                begin
                    src_idle <= src_idle - 1;
                    s_tvalid <= 1'b0;
                end
                else if (idling_on() && $urandom_range(99) < 10)
                begin
                    src_idle <= $urandom_range(14, 1) - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_queries.size() > 0)
                begin
                    s_tdata  <= pending_queries.pop_front();
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            sink_idle <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_word = day_result_t'(m_tdata);
                words_checked++;
                if (got_word.bad_date === 1'b1)
                    invalid_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("Result word %h arrived with no query outstanding", m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want_word = expected_results.pop_front();
                    if (got_word.day_difference !== want_word.day_difference)
                    begin
                        $error("day_difference mismatch: expected %0d, actual %0d",
                               want_word.day_difference, got_word.day_difference);
                        mismatch_count++;
                    end
                    if (got_word.bad_date !== want_word.bad_date)
                    begin
                        $error("bad_date mismatch: expected %0d, actual %0d",
                               want_word.bad_date, got_word.bad_date);
                        mismatch_count++;
                    end
                end
            end
            if (sink_idle > 0)
            begin
                sink_idle <= sink_idle - 1;
                m_tready  <= 1'b0;
            end
            else if (idling_on() && $urandom_range(99) < 10)
            begin
                sink_idle <= $urandom_range(14, 1) - 1;
                m_tready  <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        cal_date_t a;
        cal_date_t b;
        int        sel;
        int        drain;

        add_query(make_date(1, 1, 1), make_date(1, 1, 1), 1'b0);
        add_query(make_date(1, 1, 1), make_date(1, 1, 1), 1'b1);
        add_query(make_date(1, 1, 1), make_date(31, 12, MAX_YEAR), 1'b1);
        add_query(make_date(31, 12, MAX_YEAR), make_date(1, 1, 1), 1'b1);
        add_query(make_date(31, 12, MAX_YEAR), make_date(1, 1, 1), 1'b0);
        add_query(make_date(28, 2, 2000), make_date(1, 3, 2000), 1'b0);
        add_query(make_date(29, 2, 1900), make_date(1, 3, 1900), 1'b0);
        add_query(make_date(29, 2, 2400), make_date(1, 1, 2401), 1'b1);
        add_query(make_date(1, 1, 2023), make_date(29, 2, 2023), 1'b0);
        add_query(make_date(0, 5, 1987), make_date(3, 5, 1987), 1'b0);
        add_query(make_date(10, 0, 1500), make_date(10, 6, 1500), 1'b1);
        add_query(make_date(10, 6, 1500), make_date(10, 13, 1500), 1'b0);
        add_query(make_date(31, 15, 16383), make_date(31, 15, 16383), 1'b1);
        add_query(make_date(5, 5, 0), make_date(5, 5, 5), 1'b0);
        add_query(make_date(5, 5, 5), make_date(5, 5, MAX_YEAR + 1), 1'b1);
        add_query(make_date(31, 4, 2021), make_date(1, 5, 2021), 1'b0);
        add_query(make_date(31, 12, 1999), make_date(1, 1, 2000), 1'b0);
        add_query(make_date(1, 1, 2000), make_date(31, 12, 1999), 1'b0);
        add_query(make_date(15, 6, 2024), make_date(15, 6, 1024), 1'b0);
        add_query(make_date(31, 1, MAX_YEAR), make_date(31, 1, 1), 1'b1);
        add_query(make_date(29, 2, 2004), make_date(29, 2, 2000), 1'b1);
        add_query(make_date(30, 11, 8192), make_date(31, 10, 4096), 1'b0);

        for (int i = 0; i < RANDOM_COUNT; i++)
        begin
            sel = $urandom_range(99);
            a   = random_date();
            b   = random_date();
            if (sel < 15)
            begin
                b.y = a.y;
                if ($urandom_range(1) == 1)
                    b.m = a.m;
                b.d = $urandom_range(month_length(b.m, b.y), 1);
            end
            else if (sel < 22)
            begin
                b = a;
            end
            else if (sel < 36)
            begin
                if ($urandom_range(1) == 1)
                    a = corrupt_date(a);
                else
                    b = corrupt_date(b);
            end
            else if (sel < 46)
            begin
                a = make_date($urandom_range(31), $urandom_range(15), $urandom_range(16383));
                b = make_date($urandom_range(31), $urandom_range(15), $urandom_range(16383));
            end
            add_query(a, b, $urandom_range(1) == 1);
        end
        query_count = pending_queries.size();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_queries.size() != 0 || s_tvalid)
            @(posedge clk);
        drain = 0;
        while (expected_results.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        if (expected_results.size() != 0)
        begin
            $error("%0d result words never arrived", expected_results.size());
            mismatch_count++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d date pairs and checked %0d result words, %0d of them invalid dates,",
                 query_count, words_checked, invalid_seen);
        $display("with random stalls on both sides and a stall-free final stretch.");
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
